// ===== hdl/pulse_width_averager_core_assert.svh =====
// Assertion macros shared by the modules of the pulse width averager.
// Both macros sample on clk and are disabled while arst_n is low.
`ifndef PULSE_WIDTH_AVERAGER_CORE_ASSERT_SVH
`define PULSE_WIDTH_AVERAGER_CORE_ASSERT_SVH

// Invariant that must hold at every clock edge.
`define PWA_ASSERT(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication checked in the same cycle.
`define PWA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/pwa_pkg.sv =====
`default_nettype none

package pwa_pkg;

	localparam int unsigned TimeW     = 32;
	localparam int unsigned CountW    = 8;
	localparam int unsigned UnitShift = 4;
	localparam int unsigned DistW     = TimeW - UnitShift;

	localparam logic [CountW-1:0] CountReset = 8'd32;

	// One queued job for the divider: the total to divide and the fresh-latch flag.
	typedef struct packed {
		logic [TimeW-1:0] total;
		logic             fresh;
	} avg_item_t;

endpackage

`default_nettype wire

// ===== hdl/pwa_front.sv =====
`default_nettype none

module pwa_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [pwa_pkg::TimeW-1:0]   edge_time,
	input  wire logic                        level_high,
	input  wire logic [pwa_pkg::CountW-1:0]  count_eff,
	input  wire logic                        full,
	output logic                             push,
	output pwa_pkg::avg_item_t               push_item
);

	logic [pwa_pkg::TimeW-1:0]  start_time_q;
	logic [pwa_pkg::TimeW-1:0]  width_sum_q;
	logic [pwa_pkg::CountW-1:0] pulse_count_q;
	logic [pwa_pkg::TimeW-1:0]  latched_total_q;

	logic [pwa_pkg::TimeW-1:0]  width_new;
	logic [pwa_pkg::CountW-1:0] count_inc;
	logic                       latch;

	assign in_ready  = !full;
	assign push      = in_valid && !full;

	// The pulse width wraps modulo 2^32, as does the running sum.
	assign width_new = width_sum_q + (edge_time - start_time_q);
	assign count_inc = pulse_count_q + 8'd1;
	assign latch     = !level_high && (count_inc >= count_eff);

	assign push_item.total = latch ? width_new : latched_total_q;
	assign push_item.fresh = latch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q    <= '0;
			width_sum_q     <= '0;
			pulse_count_q   <= '0;
			latched_total_q <= '0;
		end else if (push) begin
			if (level_high) begin
				start_time_q <= edge_time;
			end else if (latch) begin
				latched_total_q <= width_new;
				width_sum_q     <= '0;
				pulse_count_q   <= '0;
			end else begin
				width_sum_q   <= width_new;
				pulse_count_q <= count_inc;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pwa_fifo.sv =====
`default_nettype none

module pwa_fifo #(
	parameter int unsigned DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire pwa_pkg::avg_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output pwa_pkg::avg_item_t      pop_item,
	output logic                    not_empty
);

`include "pulse_width_averager_core_assert.svh"

	localparam int unsigned PtrW = $clog2(DEPTH);
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	pwa_pkg::avg_item_t mem_q [DEPTH];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;

	logic do_push;
	logic do_pop;

	assign full      = (count_q == CntFull);
	assign not_empty = (count_q != '0);
	assign pop_item  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`PWA_ASSERT(a_count_bound, count_q <= CntFull, "queue fill count exceeds depth")
	`PWA_ASSERT(a_no_push_full, !(push && full), "item pushed into a full queue")

endmodule

`default_nettype wire

// ===== hdl/pwa_div.sv =====
`default_nettype none

module pwa_div (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        item_valid,
	input  wire pwa_pkg::avg_item_t          item,
	output logic                             pop,
	input  wire logic [pwa_pkg::CountW-1:0]  divisor,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [31:0]                      m_tdata,
	output logic                             m_tuser
);

`include "pulse_width_averager_core_assert.svh"

	localparam int unsigned StepW = $clog2(pwa_pkg::TimeW);
	localparam logic [StepW-1:0] StepLast = StepW'(pwa_pkg::TimeW - 1);

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		DONE
	} div_state_t;

	div_state_t                  state_q;
	logic [StepW-1:0]            step_q;
	logic [pwa_pkg::TimeW-1:0]   quot_q;
	logic [pwa_pkg::CountW-1:0]  rem_q;
	logic [pwa_pkg::CountW-1:0]  div_q;
	logic                        fresh_q;
	logic                        out_valid_q;
	logic [pwa_pkg::DistW-1:0]   out_dist_q;
	logic                        out_fresh_q;

	logic [pwa_pkg::CountW:0]    trial;
	logic [pwa_pkg::CountW:0]    diff;
	logic                        ge;

	// Restoring division, one quotient bit per cycle; the dividend shifts out
	// of quot_q from the top while quotient bits shift in at the bottom.
	assign trial = {rem_q, quot_q[pwa_pkg::TimeW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	assign pop      = (state_q == IDLE) && item_valid;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(32 - pwa_pkg::DistW){1'b0}}, out_dist_q};
	assign m_tuser  = out_fresh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			step_q      <= '0;
			quot_q      <= '0;
			rem_q       <= '0;
			div_q       <= 8'd1;
			fresh_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_dist_q  <= '0;
			out_fresh_q <= 1'b0;
		end else begin
			// In DONE the output register is reloaded below instead.
			if (out_valid_q && m_tready && (state_q != DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					if (item_valid) begin
						quot_q  <= item.total;
						fresh_q <= item.fresh;
						div_q   <= divisor;
						rem_q   <= '0;
						step_q  <= '0;
						state_q <= RUN;
					end
				end
				RUN: begin
					quot_q <= {quot_q[pwa_pkg::TimeW-2:0], ge};
					rem_q  <= ge ? diff[pwa_pkg::CountW-1:0] : trial[pwa_pkg::CountW-1:0];
					step_q <= step_q + 1'b1;
					if (step_q == StepLast) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!out_valid_q || m_tready) begin
						out_dist_q  <= quot_q[pwa_pkg::TimeW-1:pwa_pkg::UnitShift];
						out_fresh_q <= fresh_q;
						out_valid_q <= 1'b1;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	`PWA_ASSERT_IMPL(a_rem_below_div, state_q == RUN, rem_q < div_q, "remainder not below divisor")
	`PWA_ASSERT_IMPL(a_out_from_done, $rose(out_valid_q), $past(state_q) == DONE, "result without finished divide")

endmodule

`default_nettype wire

// ===== hdl/pulse_width_averager_core.sv =====
// Pulse width averager.
// Input stream (s_*): one item per captured edge; s_tdata holds the 32-bit timer
// value and s_tuser the pin level after the edge (1 rising, 0 falling).
// Output stream (m_*): one item per input item, in order; m_tdata[27:0] holds the
// averaged width divided by 16, m_tuser is high when that item latched a new total.
// Configuration (cfg_*): 8-bit average count; zero acts as one. The user must
// write it only while no item is in flight; the block does not enforce this.
// cfg_ready is always high. The front stage updates the pulse state in the cycle an
// item is accepted and queues the total; a 32-step restoring divider then produces
// the result bit by bit, one item at a time, taking the next item only from IDLE.
// The queue (QUEUE_DEPTH items) lets the front take items while the divider
// works; s_tready falls only when the queue is full.
// If the receiver stalls, the result is held in the output register, the divider
// finishes its next item and waits, and the queue then fills.
// Reset clears the pulse state and all queued items and sets the count to 32.
`default_nettype none

module pulse_width_averager_core #(
	parameter int unsigned QUEUE_DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,   // [31:0] edge_time
	input  wire logic         s_tuser,   // [0] level_high
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [31:0]       m_tdata,   // [27:0] distance_mm, [31:28] zero
	output logic              m_tuser,   // [0] new_average
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [7:0]   cfg_data   // [7:0] average_count
);

	logic [pwa_pkg::CountW-1:0] average_count_q;
	logic [pwa_pkg::CountW-1:0] count_eff;

	logic               full;
	logic               push;
	pwa_pkg::avg_item_t push_item;
	logic               pop;
	pwa_pkg::avg_item_t pop_item;
	logic               not_empty;

	assign cfg_ready = 1'b1;
	assign count_eff = (average_count_q == '0) ? 8'd1 : average_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			average_count_q <= pwa_pkg::CountReset;
		end else if (cfg_valid) begin
			average_count_q <= cfg_data;
		end
	end

	pwa_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.edge_time  (s_tdata),
		.level_high (s_tuser),
		.count_eff  (count_eff),
		.full       (full),
		.push       (push),
		.push_item  (push_item)
	);

	pwa_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_item  (pop_item),
		.not_empty (not_empty)
	);

	pwa_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (not_empty),
		.item       (pop_item),
		.pop        (pop),
		.divisor    (count_eff),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none

module tb_top;

	localparam int CycleLimit = 1000000;
	localparam int PrintCap   = 30;

	typedef struct packed {
		logic [pwa_pkg::TimeW-1:0] stamp;
		logic                      rising;
	} capture_t;

	typedef struct packed {
		logic [pwa_pkg::DistW-1:0] distance;
		logic                      fresh;
	} reading_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata   = '0;   // [31:0] edge_time
	logic              s_tuser   = 1'b0; // [0] level_high
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [31:0]       m_tdata;          // [27:0] distance_mm, [31:28] zero
	logic              m_tuser;          // [0] new_average
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [7:0]        cfg_data  = '0;   // [7:0] average_count

	// Predicted pulse state and the count the block was last given.
	logic [pwa_pkg::CountW-1:0] avg_count   = pwa_pkg::CountReset;
	logic [pwa_pkg::TimeW-1:0]  pulse_start = '0;
	logic [pwa_pkg::TimeW-1:0]  width_acc   = '0;
	logic [pwa_pkg::CountW-1:0] pulses_seen = '0;
	logic [pwa_pkg::TimeW-1:0]  held_total  = '0;

	capture_t          capture_q[$];
	reading_t          reading_q[$];

	int                items_issued  = 0;
	int                readings_seen = 0;
	int                mismatches    = 0;
	int                cycles        = 0;
	int                tx_wait       = 0;
	int                rx_wait       = 0;
	bit                tx_burst      = 1'b0;
	bit                rx_burst      = 1'b0;
	logic [pwa_pkg::TimeW-1:0] timer_now = '0;

	pulse_width_averager_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int draw_wait(bit burst);
		return burst ? 0 : $urandom_range(0, 19);
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] want,
			input logic [31:0] got);
		mismatches++;
		if (mismatches <= PrintCap)
			$display("%0t: %s: expected 0x%08h, got 0x%08h", $time, what, want, got);
	endtask

	task automatic predict_reading(input logic [pwa_pkg::TimeW-1:0] stamp, input logic rising);
		logic [pwa_pkg::TimeW-1:0] divisor;
		reading_t                  r;
		divisor = (avg_count == '0) ? pwa_pkg::TimeW'(1) : pwa_pkg::TimeW'(avg_count);
		r.fresh = 1'b0;
		if (rising) begin
			pulse_start = stamp;
		end else begin
			width_acc   = width_acc + (stamp - pulse_start);
			pulses_seen = pulses_seen + 1'b1;
			// Compared after the increment, so a lowered count latches on the next falling edge.
			if (pwa_pkg::TimeW'(pulses_seen) >= divisor) begin
				pulses_seen = '0;
				held_total  = width_acc;
				width_acc   = '0;
				r.fresh     = 1'b1;
			end
		end
		r.distance = pwa_pkg::DistW'((held_total / divisor) >> pwa_pkg::UnitShift);
		reading_q.push_back(r);
	endtask

	task automatic check_reading();
		reading_t want;
		if (reading_q.size() == 0) begin
			report_mismatch("result with nothing expected", '0, m_tdata);
		end else begin
			want = reading_q.pop_front();
			if (m_tdata !== 32'(want.distance))
				report_mismatch("distance_mm", 32'(want.distance), m_tdata);
			if (m_tuser !== want.fresh)
				report_mismatch("new_average", 32'(want.fresh), 32'(m_tuser));
		end
	endtask

	// Sender: one gap drawn per item, then the item is held until taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
			tx_wait = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_reading(s_tdata, s_tuser);
				if ($urandom_range(0, 39) == 0)
					tx_burst = !tx_burst;
				tx_wait = draw_wait(tx_burst);
			end
			if (!s_tvalid || s_tready) begin
				if (tx_wait > 0) begin
					tx_wait--;
					s_tvalid <= 1'b0;
				end else if (capture_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata  <= capture_q[0].stamp;
					s_tuser  <= capture_q[0].rising;
					void'(capture_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stalls a drawn number of cycles after each item it takes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rx_wait = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_reading();
				readings_seen++;
				if ($urandom_range(0, 39) == 0)
					rx_burst = !rx_burst;
				rx_wait = draw_wait(rx_burst);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			m_tready <= (rx_wait == 0);
		end
	end

	always @(posedge clk) begin
		cycles = cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_capture(input logic [pwa_pkg::TimeW-1:0] stamp, input logic rising);
		capture_t c;
		c.stamp  = stamp;
		c.rising = rising;
		capture_q.push_back(c);
		items_issued++;
	endtask

	// Every item returns exactly one result, so the block is idle once all are back.
	task automatic settle();
		while (readings_seen < items_issued)
			@(posedge clk);
	endtask

	task automatic set_average_count(input logic [pwa_pkg::CountW-1:0] value);
		settle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		avg_count = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_random_pulses(input int count);
		int                        n;
		logic [pwa_pkg::TimeW-1:0] width;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 9) == 0) begin
				// Stray edge with an arbitrary timestamp.
				queue_capture($urandom, 1'($urandom_range(0, 1)));
				n++;
			end else begin
				case ($urandom_range(0, 7))
					0: width = $urandom;
					1: width = 32'hFFFF_FFFF - $urandom_range(0, 255);
					2: width = $urandom_range(0, 15);
					default: width = $urandom_range(16, 200000);
				endcase
				if ($urandom_range(0, 15) == 0)
					timer_now = $urandom;
				queue_capture(timer_now, 1'b1);
				queue_capture(timer_now + width, 1'b0);
				timer_now = timer_now + width + $urandom_range(0, 1 << 20);
				n += 2;
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default count: a falling edge before any rising edge, a timer wrap inside
		// one pulse, back-to-back rising edges and a zero-width pulse.
		queue_capture(32'hFFFF_FFFF, 1'b0);
		queue_capture(32'hFFFF_FFF0, 1'b1);
		queue_capture(32'h0000_0010, 1'b0);
		queue_capture(32'h0000_0000, 1'b1);
		queue_capture(32'h8000_0000, 1'b1);
		queue_capture(32'h8000_0000, 1'b0);

		// A zero count acts as one: each falling edge latches, the widest pulse
		// gives the largest distance, and a rising edge repeats it.
		set_average_count(8'd0);
		queue_capture(32'h0000_0000, 1'b1);
		queue_capture(32'hFFFF_FFFF, 1'b0);
		queue_capture(32'h0000_1234, 1'b1);
		queue_capture(32'h5555_5555, 1'b0);
		queue_capture(32'hAAAA_AAAA, 1'b0);

		// Two maximal widths wrap the accumulator.
		set_average_count(8'd2);
		queue_capture(32'h0000_0000, 1'b1);
		queue_capture(32'hFFFF_FFFF, 1'b0);
		queue_capture(32'h0000_0001, 1'b1);
		queue_capture(32'h0000_0000, 1'b0);

		// Lowering the count below the pulses already summed latches on the next edge.
		set_average_count(8'd10);
		queue_capture(32'h0000_0100, 1'b1);
		queue_capture(32'h0000_0200, 1'b0);
		queue_capture(32'h0000_0300, 1'b0);
		queue_capture(32'h0000_0400, 1'b0);
		queue_capture(32'h0000_0500, 1'b0);
		set_average_count(8'd3);
		queue_capture(32'h0000_0600, 1'b0);

		// The held total is divided by whatever count is current.
		set_average_count(8'd255);
		queue_capture(32'h0000_0700, 1'b1);
		set_average_count(8'd1);
		queue_capture(32'h0000_0800, 1'b1);

		for (int phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 6))
				0: set_average_count(8'd0);
				1: set_average_count(8'd255);
				2: set_average_count(8'($urandom_range(1, 4)));
				3: set_average_count(8'($urandom_range(1, 16)));
				4: set_average_count(8'($urandom_range(1, 255)));
				5: set_average_count(8'd1);
				default: settle();
			endcase
			queue_random_pulses(150);
		end

		settle();
		repeat (60) @(posedge clk);
		if (reading_q.size() != 0)
			report_mismatch("results never delivered", 32'(reading_q.size()), '0);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
